@@ rtl/csl_pkg.sv @@
// Shared types, codes and character-class functions for the C subset lexer.
// Used by rtl/c_subset_lexer.sv; depends on nothing else.
package csl_pkg;

    localparam int POS_W   = 16;
    localparam int NUM_W   = 31;
    localparam int KW_MAX  = 8;
    localparam int KW_NUM  = 21;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

    // token kinds
    localparam logic [2:0] KIND_SIGN  = 3'd0;
    localparam logic [2:0] KIND_MULTI = 3'd1;
    localparam logic [2:0] KIND_KEYW  = 3'd2;
    localparam logic [2:0] KIND_IDENT = 3'd3;
    localparam logic [2:0] KIND_NUM   = 3'd4;
    localparam logic [2:0] KIND_STR   = 3'd5;
    localparam logic [2:0] KIND_END   = 3'd6;
    localparam logic [2:0] KIND_ERR   = 3'd7;

    // multi-character operator indexes
    localparam logic [4:0] OP_ELLIPSIS = 5'd0;
    localparam logic [4:0] OP_ARROW    = 5'd1;
    localparam logic [4:0] OP_LOR      = 5'd2;
    localparam logic [4:0] OP_LAND     = 5'd3;
    localparam logic [4:0] OP_EQ       = 5'd4;
    localparam logic [4:0] OP_NE       = 5'd5;
    localparam logic [4:0] OP_ADD_EQ   = 5'd6;
    localparam logic [4:0] OP_SUB_EQ   = 5'd7;
    localparam logic [4:0] OP_MUL_EQ   = 5'd8;
    localparam logic [4:0] OP_DIV_EQ   = 5'd9;
    localparam logic [4:0] OP_MOD_EQ   = 5'd10;
    localparam logic [4:0] OP_SHL_EQ   = 5'd11;
    localparam logic [4:0] OP_SHR_EQ   = 5'd12;
    localparam logic [4:0] OP_AND_EQ   = 5'd13;
    localparam logic [4:0] OP_XOR_EQ   = 5'd14;
    localparam logic [4:0] OP_OR_EQ    = 5'd15;
    localparam logic [4:0] OP_SHR      = 5'd16;
    localparam logic [4:0] OP_SHL      = 5'd17;
    localparam logic [4:0] OP_INC      = 5'd18;
    localparam logic [4:0] OP_DEC      = 5'd19;

    // register index
    localparam logic REG_FIRST_LINE = 1'b0;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // keyword text, first character in the most significant used byte
    localparam logic [8*KW_MAX-1:0] KW_TEXT [KW_NUM] = '{
        "void", "int", "char", "bool", "long", "struct", "enum", "return",
        "if", "else", "switch", "case", "default", "while", "for", "break",
        "continue", "sizeof", "extern", "include", "typedef"
    };
    localparam logic [3:0] KW_LEN [KW_NUM] = '{
        4'd4, 4'd3, 4'd4, 4'd4, 4'd4, 4'd6, 4'd4, 4'd6, 4'd2, 4'd4, 4'd6,
        4'd4, 4'd7, 4'd5, 4'd3, 4'd5, 4'd8, 4'd6, 4'd6, 4'd7, 4'd7
    };

    typedef struct packed {
        logic [2:0]       kind;
        logic [7:0]       code;
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] length;
        logic [NUM_W-1:0] num;
        logic [POS_W-1:0] line;
        logic             last;
    } tok_t;

    function automatic tok_t mk_tok(logic [2:0] kind, logic [7:0] code,
                                    logic [POS_W-1:0] start, logic [POS_W-1:0] length,
                                    logic [NUM_W-1:0] num, logic [POS_W-1:0] line);
        tok_t t;
        t.kind = kind; t.code = code; t.start = start; t.length = length;
        t.num = num; t.line = line; t.last = 1'b0;
        return t;
    endfunction

    function automatic logic [POS_W-1:0] sat_inc(logic [POS_W-1:0] x);
        return (x == POS_MAX) ? x : x + 1'b1;
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    endfunction

    function automatic logic is_single(logic [7:0] c);
        return c inside {"+", "-", "*", "/", "%", ";", "=", ",", "&", ":", "(", ")",
                         8'h5C, "#", "[", "]", ".", "~", "!", "<", ">", "|", "^",
                         "{", "}"};
    endfunction

    function automatic logic op_starter(logic [7:0] c);
        return c inside {".", "-", "|", "&", "=", "!", "+", "*", "/", "%", "<", ">", "^"};
    endfunction

    // exact two-character operator: {hit, index}
    function automatic logic [5:0] op2_exact(logic [7:0] a, logic [7:0] b);
        logic [5:0] r;
        r = '0;
        case ({a, b})
            "->":    r = {1'b1, OP_ARROW};
            "||":    r = {1'b1, OP_LOR};
            "&&":    r = {1'b1, OP_LAND};
            "==":    r = {1'b1, OP_EQ};
            "!=":    r = {1'b1, OP_NE};
            "+=":    r = {1'b1, OP_ADD_EQ};
            "-=":    r = {1'b1, OP_SUB_EQ};
            "*=":    r = {1'b1, OP_MUL_EQ};
            "/=":    r = {1'b1, OP_DIV_EQ};
            "%=":    r = {1'b1, OP_MOD_EQ};
            "&=":    r = {1'b1, OP_AND_EQ};
            "^=":    r = {1'b1, OP_XOR_EQ};
            "|=":    r = {1'b1, OP_OR_EQ};
            ">>":    r = {1'b1, OP_SHR};
            "<<":    r = {1'b1, OP_SHL};
            "++":    r = {1'b1, OP_INC};
            "--":    r = {1'b1, OP_DEC};
            default: r = '0;
        endcase
        return r;
    endfunction

    // two characters that a three-character operator extends
    function automatic logic op2_longer(logic [7:0] a, logic [7:0] b);
        return ({a, b} == 16'("..")) || ({a, b} == 16'("<<")) || ({a, b} == 16'(">>"));
    endfunction

    function automatic logic [5:0] op3_lookup(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        logic [5:0] r;
        r = '0;
        case ({a, b, c})
            "...":   r = {1'b1, OP_ELLIPSIS};
            "<<=":   r = {1'b1, OP_SHL_EQ};
            ">>=":   r = {1'b1, OP_SHR_EQ};
            default: r = '0;
        endcase
        return r;
    endfunction

    // keyword match on the identifier head: {hit, index}
    function automatic logic [5:0] kw_lookup(logic [8*KW_MAX-1:0] head, logic [POS_W-1:0] len);
        logic [5:0] r;
        r = '0;
        for (int i = 0; i < KW_NUM; i++) begin
            if (head == KW_TEXT[i] && len == POS_W'(KW_LEN[i])) begin
                r = {1'b1, 5'(i)};
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/c_subset_lexer.sv @@
// C subset lexer: one source byte per request in, tokens out.
// Top level; depends on rtl/csl_pkg.sv.
//
// Usage:
//   s_ channel: one text byte per request in s_tdata. A zero byte ends the text:
//   pending tokens are flushed, then an end token (error token for an open string,
//   none after an error); offsets and line numbers restart for the next text.
//   m_ channel: one token per request. m_tuser carries the token kind,
//   m_tlast marks the last token caused by one input byte.
//   APB port: register 0 (byte address 0) is first_line, the line number of
//   the first line of each text. Write it only while the block is idle.
// Output: a byte's tokens are written into the registered token queue; when it is
//   empty the first of them is shown on the m_ channel straight from it.
// Throughput: one byte per cycle with m_tready high and at most one token per byte;
//   a byte can make up to three tokens, and the four-entry token queue drains one
//   token per cycle with m_tready high; s_tready drops while it holds two or more.
// Reset: aresetn (synchronous, active low) empties the queue, sets
//   first_line to 1 and puts the lexer at the start of a text.
// Stall: while m_tready is low the queue holds its tokens; once it holds two or
//   more s_tready falls and input is held off without loss.
module c_subset_lexer (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input bytes
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] text_byte
    // tokens
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [87:0]          m_tdata,   // [7:0] tok_code, [23:8] tok_start,
                                            // [39:24] tok_length, [70:40] num_value,
                                            // [86:71] tok_line, [87] zero
    output logic [2:0]           m_tuser,   // [2:0] tok_kind
    output logic                 m_tlast,   // run_last
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import csl_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_SIGN, M_LCOM, M_BCOM,
        M_SQ, M_SQ_ESC, M_DQ, M_DQ_ESC
    } mode_t;

    // lexer state
    mode_t                mode_reg, mode_next;
    logic [7:0]           pend0_reg, pend0_next, pend1_reg, pend1_next;
    logic [1:0]           pcnt_reg, pcnt_next;
    logic [8*KW_MAX-1:0]  head_reg, head_next;
    logic [POS_W-1:0]     begin_reg, begin_next;
    logic [POS_W-1:0]     len_reg, len_next;
    logic [POS_W-1:0]     tline_reg, tline_next;
    logic [NUM_W-1:0]     acc_reg, acc_next;
    logic [POS_W-1:0]     bpos_reg, bpos_next;
    logic [POS_W-1:0]     line_reg, line_next;
    logic                 star_reg, star_next;
    logic                 err_reg, err_next;
    logic [15:0]          first_reg, first_next;

    // token queue
    tok_t                 q_reg [4];
    logic [1:0]           wr_reg, rd_reg;
    logic [2:0]           cnt_reg, cnt_next;

    tok_t                 res [3];
    logic [1:0]           nres;
    logic                 s_acc, m_acc, cfg_wr;
    logic [7:0]           c;
    logic                 do_fresh, do_restart;
    logic [5:0]           hit2, hit3, hit_pp, kw;
    logic [NUM_W+3:0]     acc_wide;
    logic [7:0]           q_ch;

    assign s_acc   = s_tvalid && s_tready;
    assign m_acc   = m_tvalid && m_tready;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_FIRST_LINE) ? {16'b0, first_reg} : 32'b0;
    assign c       = s_tdata;

    // room for the worst case of three tokens from one byte
    assign s_tready = (cnt_reg <= 3'd1);
    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tuser  = q_reg[rd_reg].kind;
    assign m_tlast  = q_reg[rd_reg].last;
    assign m_tdata  = {1'b0, q_reg[rd_reg].line, q_reg[rd_reg].num, q_reg[rd_reg].length,
                       q_reg[rd_reg].start, q_reg[rd_reg].code};

    // one byte of lexing (up to three tokens and the next state) and the first_line write
    always_comb begin
        mode_next  = mode_reg;
        pend0_next = pend0_reg;
        pend1_next = pend1_reg;
        pcnt_next  = pcnt_reg;
        head_next  = head_reg;
        begin_next = begin_reg;
        len_next   = len_reg;
        tline_next = tline_reg;
        acc_next   = acc_reg;
        bpos_next  = bpos_reg;
        line_next  = line_reg;
        star_next  = star_reg;
        err_next   = err_reg;
        first_next = first_reg;
        nres       = 2'd0;
        res[0]     = '0;
        res[1]     = '0;
        res[2]     = '0;
        do_fresh   = 1'b0;
        do_restart = 1'b0;
        hit2       = op2_exact(pend0_reg, c);
        hit3       = op3_lookup(pend0_reg, pend1_reg, c);
        hit_pp     = op2_exact(pend0_reg, pend1_reg);
        kw         = kw_lookup(head_reg, len_reg);
        acc_wide   = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + (NUM_W+4)'(c - CH_ZERO);
        q_ch       = (mode_reg == M_SQ) ? CH_SQ : CH_DQ;

        if (s_acc) begin
            if (c == CH_NUL) begin
                do_restart = 1'b1;
                if (err_reg) begin
                    // error already reported: the end byte emits nothing
                end else if (mode_reg inside {M_SQ, M_SQ_ESC, M_DQ, M_DQ_ESC}) begin
                    res[nres] = mk_tok(KIND_ERR, 8'd0, begin_reg, len_reg, '0, tline_reg);
                    nres = nres + 2'd1;
                end else begin
                    case (mode_reg)
                        M_IDENT: begin
                            res[nres] = kw[5] ?
                                mk_tok(KIND_KEYW, {3'b0, kw[4:0]}, begin_reg, len_reg, '0, tline_reg) :
                                mk_tok(KIND_IDENT, 8'd0, begin_reg, len_reg, '0, tline_reg);
                            nres = nres + 2'd1;
                        end
                        M_NUMBER: begin
                            res[nres] = mk_tok(KIND_NUM, 8'd0, begin_reg, len_reg, acc_reg, tline_reg);
                            nres = nres + 2'd1;
                        end
                        M_SIGN: begin
                            if (pcnt_reg == 2'd1) begin
                                res[nres] = mk_tok(KIND_SIGN, pend0_reg, begin_reg, 16'd1, '0, tline_reg);
                                nres = nres + 2'd1;
                            end else if (hit_pp != 6'd0) begin
                                res[nres] = mk_tok(KIND_MULTI, {3'b0, hit_pp[4:0]},
                                    begin_reg, 16'd2, '0, tline_reg);
                                nres = nres + 2'd1;
                            end else begin
                                // two dots with no third: two single signs
                                res[nres] = mk_tok(KIND_SIGN, pend0_reg, begin_reg, 16'd1, '0, tline_reg);
                                nres = nres + 2'd1;
                                res[nres] = mk_tok(KIND_SIGN, pend1_reg, sat_inc(begin_reg), 16'd1,
                                                   '0, tline_reg);
                                nres = nres + 2'd1;
                            end
                        end
                        default: ;
                    endcase
                    res[nres] = mk_tok(KIND_END, 8'd0, bpos_reg, 16'd0, '0, line_reg);
                    nres = nres + 2'd1;
                end
            end else if (!err_reg) begin
                case (mode_reg)
                    M_IDENT: begin
                        if (is_letter(c) || is_digit(c)) begin
                            if (len_reg < POS_W'(KW_MAX)) head_next = {head_reg[8*KW_MAX-9:0], c};
                            len_next = sat_inc(len_reg);
                        end else begin
                            res[nres] = kw[5] ?
                                mk_tok(KIND_KEYW, {3'b0, kw[4:0]}, begin_reg, len_reg, '0, tline_reg) :
                                mk_tok(KIND_IDENT, 8'd0, begin_reg, len_reg, '0, tline_reg);
                            nres = nres + 2'd1;
                            do_fresh = 1'b1;
                        end
                    end
                    M_NUMBER: begin
                        if (is_digit(c)) begin
                            acc_next = (acc_wide > (NUM_W+4)'(NUM_MAX)) ? NUM_MAX : acc_wide[NUM_W-1:0];
                            len_next = sat_inc(len_reg);
                        end else begin
                            res[nres] = mk_tok(KIND_NUM, 8'd0, begin_reg, len_reg, acc_reg, tline_reg);
                            nres = nres + 2'd1;
                            do_fresh = 1'b1;
                        end
                    end
                    M_SIGN: begin
                        if (pcnt_reg == 2'd1) begin
                            if (pend0_reg == CH_SLASH && (c == CH_SLASH || c == CH_STAR)) begin
                                pcnt_next = 2'd0;
                                mode_next = (c == CH_SLASH) ? M_LCOM : M_BCOM;
                                star_next = 1'b0;
                            end else if (hit2[5] && !op2_longer(pend0_reg, c)) begin
                                res[nres] = mk_tok(KIND_MULTI, {3'b0, hit2[4:0]}, begin_reg,
                                                   16'd2, '0, tline_reg);
                                nres = nres + 2'd1;
                                pcnt_next = 2'd0;
                                mode_next = M_IDLE;
                            end else if (op2_longer(pend0_reg, c)) begin
                                pend1_next = c;
                                pcnt_next  = 2'd2;
                            end else begin
                                res[nres] = mk_tok(KIND_SIGN, pend0_reg, begin_reg, 16'd1, '0, tline_reg);
                                nres = nres + 2'd1;
                                pcnt_next = 2'd0;
                                do_fresh  = 1'b1;
                            end
                        end else begin
                            if (hit3[5]) begin
                                res[nres] = mk_tok(KIND_MULTI, {3'b0, hit3[4:0]}, begin_reg,
                                                   16'd3, '0, tline_reg);
                                nres = nres + 2'd1;
                                pcnt_next = 2'd0;
                                mode_next = M_IDLE;
                            end else if (hit_pp != 6'd0) begin
                                res[nres] = mk_tok(KIND_MULTI, {3'b0, hit_pp[4:0]},
                                    begin_reg, 16'd2, '0, tline_reg);
                                nres = nres + 2'd1;
                                pcnt_next = 2'd0;
                                do_fresh  = 1'b1;
                            end else begin
                                res[nres] = mk_tok(KIND_SIGN, pend0_reg, begin_reg, 16'd1, '0, tline_reg);
                                nres = nres + 2'd1;
                                res[nres] = mk_tok(KIND_SIGN, pend1_reg, sat_inc(begin_reg), 16'd1,
                                                   '0, tline_reg);
                                nres = nres + 2'd1;
                                pcnt_next = 2'd0;
                                do_fresh  = 1'b1;
                            end
                        end
                    end
                    M_LCOM: begin
                        if (c == CH_NL) begin
                            line_next = sat_inc(line_reg);
                            mode_next = M_IDLE;
                        end
                    end
                    M_BCOM: begin
                        if (c == CH_NL) line_next = sat_inc(line_reg);
                        if (star_reg && c == CH_SLASH) begin
                            mode_next = M_IDLE;
                            star_next = 1'b0;
                        end else begin
                            star_next = (c == CH_STAR);
                        end
                    end
                    M_SQ, M_DQ: begin
                        if (c == q_ch) begin
                            res[nres] = mk_tok(KIND_STR, 8'd0, begin_reg, len_reg, '0, tline_reg);
                            nres = nres + 2'd1;
                            res[nres] = mk_tok(KIND_SIGN, q_ch, bpos_reg, 16'd1, '0, line_reg);
                            nres = nres + 2'd1;
                            mode_next = M_IDLE;
                        end else begin
                            if (c == CH_NL) line_next = sat_inc(line_reg);
                            len_next = sat_inc(len_reg);
                            if (c == CH_BSL) mode_next = (mode_reg == M_SQ) ? M_SQ_ESC : M_DQ_ESC;
                        end
                    end
                    M_SQ_ESC, M_DQ_ESC: begin
                        if (c == CH_NL) line_next = sat_inc(line_reg);
                        len_next  = sat_inc(len_reg);
                        mode_next = (mode_reg == M_SQ_ESC) ? M_SQ : M_DQ;
                    end
                    default: do_fresh = 1'b1;
                endcase

                // start a new token on this byte
                if (do_fresh) begin
                    mode_next = M_IDLE;
                    if (is_space(c)) begin
                        if (c == CH_NL) line_next = sat_inc(line_reg);
                    end else if (c == CH_DQ || c == CH_SQ) begin
                        res[nres] = mk_tok(KIND_SIGN, c, bpos_reg, 16'd1, '0, line_reg);
                        nres = nres + 2'd1;
                        mode_next  = (c == CH_DQ) ? M_DQ : M_SQ;
                        begin_next = sat_inc(bpos_reg);
                        len_next   = '0;
                        tline_next = line_reg;
                    end else if (is_letter(c)) begin
                        mode_next  = M_IDENT;
                        head_next  = {{(8*KW_MAX-8){1'b0}}, c};
                        begin_next = bpos_reg;
                        len_next   = 16'd1;
                        tline_next = line_reg;
                    end else if (is_digit(c)) begin
                        mode_next  = M_NUMBER;
                        acc_next   = NUM_W'(c - CH_ZERO);
                        begin_next = bpos_reg;
                        len_next   = 16'd1;
                        tline_next = line_reg;
                    end else if (op_starter(c)) begin
                        mode_next  = M_SIGN;
                        pend0_next = c;
                        pend1_next = 8'd0;
                        pcnt_next  = 2'd1;
                        begin_next = bpos_reg;
                        tline_next = line_reg;
                    end else if (is_single(c)) begin
                        res[nres] = mk_tok(KIND_SIGN, c, bpos_reg, 16'd1, '0, line_reg);
                        nres = nres + 2'd1;
                    end else begin
                        res[nres] = mk_tok(KIND_ERR, c, bpos_reg, 16'd1, '0, line_reg);
                        nres = nres + 2'd1;
                        err_next = 1'b1;
                    end
                end
                bpos_next = sat_inc(bpos_reg);
            end else begin
                bpos_next = sat_inc(bpos_reg);
            end

            if (nres != 2'd0) res[nres - 2'd1].last = 1'b1;

            // back to the start of a text
            if (do_restart) begin
                mode_next  = M_IDLE;
                pend0_next = '0;
                pend1_next = '0;
                pcnt_next  = '0;
                head_next  = '0;
                begin_next = '0;
                len_next   = '0;
                tline_next = '0;
                acc_next   = '0;
                bpos_next  = '0;
                line_next  = first_reg;
                star_next  = 1'b0;
                err_next   = 1'b0;
            end
        end

        if (cfg_wr && paddr[2] == REG_FIRST_LINE) begin
            first_next = pwdata[15:0];
            if (bpos_reg == '0) line_next = pwdata[15:0];
        end
    end

    assign cnt_next = cnt_reg + {1'b0, nres} - {2'b0, m_acc};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            pend0_reg <= '0;
            pend1_reg <= '0;
            pcnt_reg  <= '0;
            head_reg  <= '0;
            begin_reg <= '0;
            len_reg   <= '0;
            tline_reg <= '0;
            acc_reg   <= '0;
            bpos_reg  <= '0;
            line_reg  <= 16'd1;
            star_reg  <= 1'b0;
            err_reg   <= 1'b0;
            first_reg <= 16'd1;
            wr_reg    <= '0;
            rd_reg    <= '0;
            cnt_reg   <= '0;
        end else begin
            mode_reg  <= mode_next;
            pend0_reg <= pend0_next;
            pend1_reg <= pend1_next;
            pcnt_reg  <= pcnt_next;
            head_reg  <= head_next;
            begin_reg <= begin_next;
            len_reg   <= len_next;
            tline_reg <= tline_next;
            acc_reg   <= acc_next;
            bpos_reg  <= bpos_next;
            line_reg  <= line_next;
            star_reg  <= star_next;
            err_reg   <= err_next;
            first_reg <= first_next;
            wr_reg    <= wr_reg + nres;
            if (m_acc) rd_reg <= rd_reg + 2'd1;
            cnt_reg   <= cnt_next;
        end
    end

    // token queue storage
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < nres) q_reg[wr_reg + 2'(i)] <= res[i];
        end
    end

    // queue never overfills
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'd4)
        else $error("token queue overflow");

    // a zero byte restarts the byte offset
    a_text_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tdata == CH_NUL) |=> bpos_reg == '0)
        else $error("offset not restarted after end of text");

    // pending signs exist only in operator mode
    a_pending_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg != M_SIGN) |-> (pcnt_reg == 2'd0))
        else $error("stale pending signs");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for c_subset_lexer: streams source text, predicts tokens.
// Depends on rtl/csl_pkg.sv and rtl/c_subset_lexer.sv.
module tb_top;
    import csl_pkg::*;

    localparam int ST_IDLE = 0, ST_IDENT = 1, ST_NUMBER = 2, ST_SIGN = 3, ST_LCOM = 4,
                   ST_BCOM = 5, ST_SQ = 6, ST_SQ_ESC = 7, ST_DQ = 8, ST_DQ_ESC = 9;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    c_subset_lexer DUT (.*);

    always #2 aclk = ~aclk;

    // predictor state
    logic [15:0] line_base;
    int          mode;
    logic [7:0]  pend [2];
    int          pend_n;
    logic [7:0]  head [8];
    logic [15:0] tk_begin, tk_len, tk_line, pos, line_no;
    logic [30:0] acc;
    logic        star_on, err_on;

    tok_t   token_q[$];
    tok_t   step_toks[$];
    logic [7:0] text_q[$];
    int     mismatches = 0;
    int     tok_seen = 0;
    int     items_in = 0;
    int     drv_gap = 0, rcv_gap = 0, hold_cycles = 0;
    logic   feeding = 1'b0;

    string KW [21] = '{"void", "int", "char", "bool", "long", "struct", "enum", "return",
        "if", "else", "switch", "case", "default", "while", "for", "break",
        "continue", "sizeof", "extern", "include", "typedef"};
    string OPS [20] = '{"...", "->", "||", "&&", "==", "!=", "+=", "-=", "*=", "/=",
        "%=", "<<=", ">>=", "&=", "^=", "|=", ">>", "<<", "++", "--"};

    function automatic logic [15:0] bump(logic [15:0] x);
        return (x == 16'hFFFF) ? x : x + 16'd1;
    endfunction

    function automatic void put(logic [2:0] k, logic [7:0] c, logic [15:0] s,
                                logic [15:0] l, logic [30:0] n, logic [15:0] ln);
        tok_t t;
        if (step_toks.size() >= 3) return;
        t.kind = k; t.code = c; t.start = s; t.length = l; t.num = n; t.line = ln;
        t.last = 1'b0;
        step_toks.push_back(t);
    endfunction

    function automatic void restart_text();
        mode = ST_IDLE; pend_n = 0; pend[0] = 0; pend[1] = 0;
        foreach (head[i]) head[i] = 0;
        tk_begin = 0; tk_len = 0; tk_line = 0; acc = 0; pos = 0;
        line_no = line_base; star_on = 0; err_on = 0;
    endfunction

    // operator table search on m chars: any prefix match, exact index, longer exists
    function automatic logic op_find(logic [7:0] b [3], int m, output int ex,
                                     output logic lg);
        logic any = 0;
        logic ok;
        ex = -1; lg = 0;
        for (int i = 0; i < 20; i++) begin
            if (OPS[i].len() >= m) begin
                ok = 1;
                for (int j = 0; j < m; j++) if (OPS[i][j] != b[j]) ok = 0;
                if (ok) begin
                    any = 1;
                    if (OPS[i].len() == m) ex = i; else lg = 1;
                end
            end
        end
        return any;
    endfunction

    function automatic void pop_sign();
        int ex; logic lg;
        logic [7:0] b [3];
        b[0] = pend[0]; b[1] = pend[1]; b[2] = 0;
        void'(op_find(b, pend_n, ex, lg));
        if (pend_n == 2 && ex >= 0) begin
            put(KIND_MULTI, 8'(ex), tk_begin, 16'd2, 31'd0, tk_line);
            pend_n = 0;
        end else begin
            put(KIND_SIGN, pend[0], tk_begin, 16'd1, 31'd0, tk_line);
            pend[0] = pend[1]; pend_n--;
            tk_begin = bump(tk_begin);
        end
        if (pend_n == 0) mode = ST_IDLE;
    endfunction

    function automatic logic sign_take(logic [7:0] c);
        int ex; logic lg;
        logic [7:0] b [3];
        while (pend_n > 0) begin
            if (pend_n == 1 && pend[0] == "/" && (c == "/" || c == "*")) begin
                pend_n = 0; mode = (c == "/") ? ST_LCOM : ST_BCOM; star_on = 0;
                return 1;
            end
            b[0] = pend[0]; b[1] = pend[1]; b[2] = 0; b[pend_n] = c;
            if (op_find(b, pend_n + 1, ex, lg)) begin
                if ((ex >= 0 && !lg) || pend_n >= 2) begin
                    put(KIND_MULTI, 8'(ex >= 0 ? ex : 0), tk_begin, 16'(pend_n + 1), 31'd0,
                        tk_line);
                    pend_n = 0; mode = ST_IDLE;
                end else begin
                    pend[pend_n] = c; pend_n++;
                end
                return 1;
            end
            pop_sign();
        end
        mode = ST_IDLE;
        return 0;
    endfunction

    function automatic void word_out();
        logic ok;
        if (tk_len <= 8) begin
            for (int i = 0; i < 21; i++) begin
                if (KW[i].len() == tk_len) begin
                    ok = 1;
                    for (int j = 0; j < KW[i].len(); j++) if (KW[i][j] != head[j]) ok = 0;
                    if (ok) begin
                        put(KIND_KEYW, 8'(i), tk_begin, tk_len, 31'd0, tk_line);
                        return;
                    end
                end
            end
        end
        put(KIND_IDENT, 8'd0, tk_begin, tk_len, 31'd0, tk_line);
    endfunction

    function automatic logic starter(logic [7:0] c);
        for (int i = 0; i < 20; i++) if (OPS[i][0] == c) return 1;
        return 0;
    endfunction

    function automatic void begin_token(logic [7:0] c);
        mode = ST_IDLE;
        if (is_space(c)) begin
            if (c == CH_NL) line_no = bump(line_no);
        end else if (c == CH_DQ || c == CH_SQ) begin
            put(KIND_SIGN, c, pos, 16'd1, 31'd0, line_no);
            mode = (c == CH_DQ) ? ST_DQ : ST_SQ;
            tk_begin = bump(pos); tk_len = 0; tk_line = line_no;
        end else if (is_letter(c)) begin
            mode = ST_IDENT;
            foreach (head[i]) head[i] = 0;
            head[0] = c; tk_begin = pos; tk_len = 1; tk_line = line_no;
        end else if (is_digit(c)) begin
            mode = ST_NUMBER; acc = 31'(c - CH_ZERO);
            tk_begin = pos; tk_len = 1; tk_line = line_no;
        end else if (starter(c)) begin
            mode = ST_SIGN; pend[0] = c; pend[1] = 0; pend_n = 1;
            tk_begin = pos; tk_line = line_no;
        end else if (is_single(c)) begin
            put(KIND_SIGN, c, pos, 16'd1, 31'd0, line_no);
        end else begin
            put(KIND_ERR, c, pos, 16'd1, 31'd0, line_no);
            err_on = 1;
        end
    endfunction

    // advance the predictor by one text byte; tokens land in step_toks
    function automatic void lex_byte(logic [7:0] c);
        logic [7:0] q;
        logic [31:0] d;
        step_toks.delete();
        if (c == CH_NUL) begin
            if (err_on) restart_text();
            else if (mode inside {ST_SQ, ST_SQ_ESC, ST_DQ, ST_DQ_ESC}) begin
                put(KIND_ERR, 8'd0, tk_begin, tk_len, 31'd0, tk_line);
                restart_text();
            end else begin
                if (mode == ST_IDENT) word_out();
                else if (mode == ST_NUMBER) put(KIND_NUM, 8'd0, tk_begin, tk_len, acc, tk_line);
                else if (mode == ST_SIGN) while (pend_n > 0) pop_sign();
                put(KIND_END, 8'd0, pos, 16'd0, 31'd0, line_no);
                restart_text();
            end
        end else if (!err_on) begin
            case (mode)
                ST_IDENT:
                    if (is_letter(c) || is_digit(c)) begin
                        if (tk_len < 8) head[tk_len] = c;
                        tk_len = bump(tk_len);
                    end else begin
                        word_out(); begin_token(c);
                    end
                ST_NUMBER:
                    if (is_digit(c)) begin
                        d = 32'(c - CH_ZERO);
                        acc = (32'(acc) > (32'h7FFF_FFFF - d) / 10) ? NUM_MAX
                                                                     : 31'(acc * 10 + d);
                        tk_len = bump(tk_len);
                    end else begin
                        put(KIND_NUM, 8'd0, tk_begin, tk_len, acc, tk_line);
                        begin_token(c);
                    end
                ST_SIGN: if (!sign_take(c)) begin_token(c);
                ST_LCOM:
                    if (c == CH_NL) begin
                        line_no = bump(line_no); mode = ST_IDLE;
                    end
                ST_BCOM: begin
                    if (c == CH_NL) line_no = bump(line_no);
                    if (star_on && c == CH_SLASH) begin
                        mode = ST_IDLE; star_on = 0;
                    end else star_on = (c == CH_STAR);
                end
                ST_SQ, ST_DQ: begin
                    q = (mode == ST_SQ) ? CH_SQ : CH_DQ;
                    if (c == q) begin
                        put(KIND_STR, 8'd0, tk_begin, tk_len, 31'd0, tk_line);
                        put(KIND_SIGN, q, pos, 16'd1, 31'd0, line_no);
                        mode = ST_IDLE;
                    end else begin
                        if (c == CH_NL) line_no = bump(line_no);
                        tk_len = bump(tk_len);
                        if (c == CH_BSL) mode = (mode == ST_SQ) ? ST_SQ_ESC : ST_DQ_ESC;
                    end
                end
                ST_SQ_ESC, ST_DQ_ESC: begin
                    if (c == CH_NL) line_no = bump(line_no);
                    tk_len = bump(tk_len);
                    mode = (mode == ST_SQ_ESC) ? ST_SQ : ST_DQ;
                end
                default: begin_token(c);
            endcase
            pos = bump(pos);
        end else begin
            pos = bump(pos);
        end
        if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    endfunction

    // driver: present queued bytes with random gaps; predict at acceptance
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            items_in++;
            lex_byte(s_tdata);
            foreach (step_toks[i]) token_q.push_back(step_toks[i]);
        end
        if (!aresetn || !feeding) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (drv_gap > 0 || text_q.size() == 0) begin
                if (drv_gap > 0) drv_gap <= drv_gap - 1;
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata <= text_q.pop_front();
                if ($urandom_range(0, 3) == 0)
                    drv_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                          : $urandom_range(1, 3);
            end
        end
    end

    // long receiver hold-off: count down the requested cycles
    always @(posedge aclk) begin
        if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end

    // monitor: compare each accepted token with the oldest prediction
    always @(posedge aclk) begin
        tok_t exp_t, got;
        if (aresetn && m_tvalid && m_tready) begin
            tok_seen++;
            got.kind = m_tuser; got.code = m_tdata[7:0]; got.start = m_tdata[23:8];
            got.length = m_tdata[39:24]; got.num = m_tdata[70:40];
            got.line = m_tdata[86:71]; got.last = m_tlast;
            if (token_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected token %p", got);
            end else begin
                exp_t = token_q.pop_front();
                if (got !== exp_t) begin
                    mismatches++;
                    if (mismatches <= 10) $display("token mismatch exp %p got %p", exp_t, got);
                end
            end
        end
        // receiver stalls: a long hold-off when asked, otherwise random short/long gaps
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
        end else if (rcv_gap > 0) begin
            rcv_gap <= rcv_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 4) == 0)
                rcv_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                      : $urandom_range(1, 3);
        end
    end

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    // wait for all bytes to go in and all tokens to come out, then let it settle
    task automatic drain();
        while (text_q.size() > 0 || s_tvalid) @(posedge aclk);
        while (token_q.size() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic reg_write(logic [15:0] v);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {REG_FIRST_LINE, 2'b00}; pwdata <= 32'(v);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        line_base = v;
        if (pos == 0) line_no = v;
    endtask

    function automatic logic [7:0] pick_byte();
        string alpha = "abcdefghijklmnopqrstuvwxyz_ABCXYZ0123456789+-*/%=<>&|^!.;,(){}[]:~#";
        case ($urandom_range(0, 9))
            0: return 8'($urandom_range(1, 255));
            1: return " ";
            2: return CH_NL;
            3: return CH_DQ;
            default: return alpha[$urandom_range(0, alpha.len() - 1)];
        endcase
    endfunction

    task automatic random_text();
        int n;
        string s;
        n = $urandom_range(3, 25);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 11))
                0: s = KW[$urandom_range(0, 20)];
                1: s = OPS[$urandom_range(0, 19)];
                2: s = $sformatf("%0d", $urandom);
                3: s = "/* x*\n*/";
                4: s = "// c\n";
                5: s = "\"a\\\"b\"";
                6: s = "'q'";
                default: s = "";
            endcase
            if (s.len() > 0) begin
                push_text(s);
                text_q.push_back(" ");
            end else text_q.push_back(pick_byte());
        end
        text_q.push_back(CH_NUL);
    endtask

    initial begin
        line_base = 16'd1;
        restart_text();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        feeding = 1'b1;

        // directed: keywords, operators, comments, strings, saturation, errors
        push_text("continue int x<<=y...a->b; /*c*/ //d\n 2147483648 0 'a\\'' \"\" ");
        text_q.push_back(CH_NUL);
        push_text("@ a"); text_q.push_back(CH_NUL);
        push_text("\"open\n"); text_q.push_back(CH_NUL);
        push_text("/* open"); text_q.push_back(CH_NUL);
        text_q.push_back(8'hFF); text_q.push_back(CH_NUL);
        text_q.push_back(8'h80); text_q.push_back(CH_NUL);
        push_text("<<>>.. /"); text_q.push_back(CH_NUL);
        drain();

        reg_write(16'hFFFF);
        push_text("a\n\nb"); text_q.push_back(CH_NUL);
        drain();
        reg_write(16'h0000);
        push_text("void\n"); text_q.push_back(CH_NUL);
        drain();

        // hold the receiver off while bytes keep coming so the queue fills
        hold_cycles = 200;
        push_text("+ - * ; , ( ) { } [ ] ~ # : ! = % ^ & | < > . \\ + - * / +");
        text_q.push_back(CH_NUL);
        drain();

        reg_write(16'd1);
        while (items_in + text_q.size() < 250) begin
            random_text();
            if ($urandom_range(0, 5) == 0) begin
                drain();
                reg_write(16'($urandom));
            end
        end
        drain();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && token_q.size() == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
